[src/sdfv_pkg.sv]
// Shared types, constants and helpers for the voxel signed distance evaluator.
package sdfv_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [30:0] RADIUS_RST = 31'd65536;
   localparam logic [30:0] RING_RST   = 31'd65536;
   localparam logic [30:0] BAND_RST   = 31'd196608;

   typedef enum logic [1:0] {
      SHAPE_SPHERE  = 2'd0,
      SHAPE_BOX     = 2'd1,
      SHAPE_TORUS   = 2'd2,
      SHAPE_CAPSULE = 2'd3
   } shape_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHAPE_KIND  = 3'd0,
      CSR_AXIS_X      = 3'd1,
      CSR_AXIS_Y      = 3'd2,
      CSR_AXIS_Z      = 3'd3,
      CSR_RADIUS      = 3'd4,
      CSR_RING_RADIUS = 3'd5,
      CSR_BAND_LIMIT  = 3'd6
   } csr_index_type;

   typedef struct packed {
      shape_type          shape;
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      logic [30:0]        radius;
      logic [30:0]        ring_radius;
      logic [30:0]        band_limit;
   } cfg_type;

   // element 0 is x, 1 is y, 2 is z
   typedef logic [2:0][31:0] vec3_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

[src/sdfv_front.sv]
// Front end: per-shape vector setup, capsule projection divider and residual.
module sdfv_front #(
   parameter int FRAC_BITS = sdfv_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  sdfv_pkg::cfg_type  cfg,
   input  logic               in_valid,
   input  sdfv_pkg::vec3_type in_p,
   output logic               out_valid,
   output sdfv_pkg::vec3_type out_comp,
   output logic signed [32:0] out_aux,
   output logic               out_big
);

   localparam int Depth    = FRAC_BITS + 7;
   localparam int ScaleIdx = FRAC_BITS + 4;
   localparam int GenLast  = FRAC_BITS + 5;
   localparam logic [FRAC_BITS:0] HOne = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [33:0] Max31 = 34'sd2147483647;

   sdfv_pkg::vec3_type axis;
   assign axis = {cfg.axis_z, cfg.axis_y, cfg.axis_x};

   // valid and payload delay lines
   logic               v_ff [0:Depth-1];
   sdfv_pkg::vec3_type p_ff [0:ScaleIdx];
   sdfv_pkg::vec3_type g_ff [1:GenLast];
   logic signed [32:0] a_ff [1:GenLast];

   // stage 1: magnitudes, products, box excess
   sdfv_pkg::vec3_type mp, mb, mg_ff;
   logic [2:0][63:0]   pr_in, bb_in, pr_ff, bb_ff;
   logic [2:0][33:0]   q_in, q_ff;
   logic [2:0]         sn_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mp[i]    = sdfv_pkg::mag32(in_p[i]);
         mb[i]    = sdfv_pkg::mag32(axis[i]);
         pr_in[i] = mp[i] * mb[i];
         bb_in[i] = mb[i] * mb[i];
         q_in[i]  = {2'b00, mp[i]} - {{2{axis[i][31]}}, axis[i]};
      end
   end

   always_ff @(posedge clock) begin
      pr_ff <= pr_in;
      bb_ff <= bb_in;
      q_ff  <= q_in;
      mg_ff <= mp;
      for (int i = 0; i < 3; i++) begin
         sn_ff[i] <= in_p[i][31] ^ axis[i][31];
      end
   end

   // stage 2: dot products, generic vector for the non-capsule shapes
   logic [63:0]        baba2_in, pos2_in, neg2_in, baba2_ff, pos2_ff, neg2_ff;
   logic signed [33:0] qmax;
   sdfv_pkg::vec3_type ox, g_in;
   logic signed [32:0] aux_in;

   always_comb begin
      baba2_in = bb_ff[0] + bb_ff[1] + bb_ff[2];
      pos2_in  = '0;
      neg2_in  = '0;
      for (int i = 0; i < 3; i++) begin
         if (sn_ff[i]) begin
            neg2_in = neg2_in + pr_ff[i];
         end else begin
            pos2_in = pos2_in + pr_ff[i];
         end
      end
      qmax = $signed(q_ff[0]);
      if ($signed(q_ff[1]) > qmax) begin
         qmax = $signed(q_ff[1]);
      end
      if ($signed(q_ff[2]) > qmax) begin
         qmax = $signed(q_ff[2]);
      end
      for (int i = 0; i < 3; i++) begin
         if ($signed(q_ff[i]) <= 34'sd0) begin
            ox[i] = '0;
         end else if ($signed(q_ff[i]) > Max31) begin
            ox[i] = 32'h7fffffff;
         end else begin
            ox[i] = q_ff[i][31:0];
         end
      end
      g_in   = '0;
      aux_in = '0;
      case (cfg.shape)
         sdfv_pkg::SHAPE_SPHERE: begin
            g_in = mg_ff;
         end
         sdfv_pkg::SHAPE_BOX: begin
            g_in   = ox;
            aux_in = (qmax > 34'sd0) ? 33'sd0 : $signed(qmax[32:0]);
         end
         sdfv_pkg::SHAPE_TORUS: begin
            g_in[0] = mg_ff[0];
            g_in[2] = mg_ff[2];
            aux_in  = $signed({1'b0, mg_ff[1]});
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      baba2_ff <= baba2_in;
      pos2_ff  <= pos2_in;
      neg2_ff  <= neg2_in;
   end

   // stage 3: projection numerator
   logic [63:0] r3_ff, baba3_ff;
   logic        nz3_ff;

   always_ff @(posedge clock) begin
      r3_ff    <= pos2_ff - neg2_ff;
      baba3_ff <= baba2_ff;
      nz3_ff   <= (pos2_ff > neg2_ff) && (baba2_ff != '0);
   end

   // stage 4 and divider: one quotient bit per stage
   logic [63:0]          dr_ff   [0:FRAC_BITS-1];
   logic [63:0]          db_ff   [0:FRAC_BITS-1];
   logic [FRAC_BITS-1:0] dh_ff   [1:FRAC_BITS];
   logic                 full_ff [0:FRAC_BITS];
   logic                 zero_ff [0:FRAC_BITS];

   always_ff @(posedge clock) begin
      dr_ff[0]   <= r3_ff;
      db_ff[0]   <= baba3_ff;
      full_ff[0] <= nz3_ff && (r3_ff >= baba3_ff);
      zero_ff[0] <= !nz3_ff;
   end

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
      logic [64:0]          twice, rest;
      logic                 take;
      logic [FRAC_BITS-1:0] h_prev;

      assign twice = {dr_ff[k], 1'b0};
      assign rest  = twice - {1'b0, db_ff[k]};
      assign take  = twice >= {1'b0, db_ff[k]};

      if (k == 0) begin : g_first
         assign h_prev = '0;
      end else begin : g_rest
         assign h_prev = dh_ff[k];
      end

      always_ff @(posedge clock) begin
         dh_ff[k+1]   <= {h_prev[FRAC_BITS-2:0], take};
         full_ff[k+1] <= full_ff[k];
         zero_ff[k+1] <= zero_ff[k];
      end

      if (k < FRAC_BITS - 1) begin : g_next
         always_ff @(posedge clock) begin
            dr_ff[k+1] <= take ? rest[63:0] : twice[63:0];
            db_ff[k+1] <= db_ff[k];
         end
      end
   end

   // scale: axis times clamped factor, truncated
   logic [FRAC_BITS:0]             hf;
   logic [2:0][FRAC_BITS+31:0]     prod;
   sdfv_pkg::vec3_type             s_in, s_ff;

   always_comb begin
      if (full_ff[FRAC_BITS]) begin
         hf = HOne;
      end else if (zero_ff[FRAC_BITS]) begin
         hf = '0;
      end else begin
         hf = {1'b0, dh_ff[FRAC_BITS]};
      end
      for (int i = 0; i < 3; i++) begin
         prod[i] = mb[i] * hf;
         s_in[i] = prod[i][FRAC_BITS+31:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   // residual p - axis * h
   logic [2:0][33:0] e_in, e_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (axis[i][31]) begin
            e_in[i] = {{2{p_ff[ScaleIdx][i][31]}}, p_ff[ScaleIdx][i]} + {2'b00, s_ff[i]};
         end else begin
            e_in[i] = {{2{p_ff[ScaleIdx][i][31]}}, p_ff[ScaleIdx][i]} - {2'b00, s_ff[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
   end

   // magnitude, halve all three when one does not fit 31 bits
   logic [2:0][32:0]   dm;
   sdfv_pkg::vec3_type cc;
   logic               big;

   always_comb begin
      big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         dm[i] = e_ff[i][33] ? 33'(~e_ff[i] + 34'd1) : e_ff[i][32:0];
         big   = big | (dm[i][32:31] != 2'b00);
      end
      for (int i = 0; i < 3; i++) begin
         cc[i] = big ? dm[i][32:1] : dm[i][31:0];
      end
   end

   sdfv_pkg::vec3_type comp_ff;
   logic signed [32:0] aux_ff;
   logic               big_ff;

   always_ff @(posedge clock) begin
      if (cfg.shape == sdfv_pkg::SHAPE_CAPSULE) begin
         comp_ff <= cc;
         aux_ff  <= '0;
         big_ff  <= big;
      end else begin
         comp_ff <= g_ff[GenLast];
         aux_ff  <= a_ff[GenLast];
         big_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= in_p;
      for (int i = 1; i <= ScaleIdx; i++) begin
         p_ff[i] <= p_ff[i-1];
      end
      g_ff[1] <= g_in;
      a_ff[1] <= aux_in;
      for (int i = 2; i <= GenLast; i++) begin
         g_ff[i] <= g_ff[i-1];
         a_ff[i] <= a_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < Depth; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   assign out_valid = v_ff[Depth-1];
   assign out_comp  = comp_ff;
   assign out_aux   = aux_ff;
   assign out_big   = big_ff;

`ifndef SYNTHESIS
   a_comp_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_comp[0] <= 32'h80000000) && (out_comp[1] <= 32'h80000000)
                    && (out_comp[2] <= 32'h80000000))
      else $error("square root operand exceeds 2^31");
`endif

endmodule

[src/sdfv_isqrt.sv]
// Pipelined square root of a sum of three squares, one root bit per stage.
module sdfv_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  sdfv_pkg::vec3_type in_a,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [31:0]        out_root,
   output logic [SIDE_W-1:0]  out_side
);

   localparam int Steps = 32;
   localparam int Depth = Steps + 2;

   logic              v_ff    [0:Depth-1];
   logic [SIDE_W-1:0] side_ff [0:Depth-1];
   logic [2:0][63:0]  sq_ff;
   logic [63:0]       rem_ff  [0:Steps-1];
   logic [63:0]       root_ff [1:Steps];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= in_a[i] * in_a[i];
      end
      rem_ff[0] <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   for (genvar k = 0; k < Steps; k++) begin : g_step
      localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
      logic [63:0] r_prev, trial;
      logic        fit;

      if (k == 0) begin : g_first
         assign r_prev = '0;
      end else begin : g_rest
         assign r_prev = root_ff[k];
      end

      assign trial = r_prev + Bit;
      assign fit   = rem_ff[k] >= trial;

      always_ff @(posedge clock) begin
         root_ff[k+1] <= fit ? (r_prev >> 1) + Bit : (r_prev >> 1);
      end

      if (k < Steps - 1) begin : g_next
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= fit ? rem_ff[k] - trial : rem_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int i = 1; i < Depth; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < Depth; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   assign out_valid = v_ff[Depth-1];
   assign out_root  = root_ff[Steps][31:0];
   assign out_side  = side_ff[Depth-1];

endmodule

[src/sdfv_final.sv]
// Back end: per-shape distance assembly and band clamp.
module sdfv_final (
   input  logic               clock,
   input  logic               reset,
   input  sdfv_pkg::cfg_type  cfg,
   input  logic               in_valid,
   input  logic [31:0]        in_root1,
   input  logic [31:0]        in_root2,
   input  logic signed [32:0] in_aux,
   input  logic               in_big,
   output logic               out_strobe,
   output logic signed [31:0] out_distance
);

   logic signed [35:0] rad, band, nband, d_in, d_ff;
   logic signed [31:0] dist_in, dist_ff;
   logic               v_ff, strobe_ff;

   assign rad   = $signed({5'b00000, cfg.radius});
   assign band  = $signed({5'b00000, cfg.band_limit});
   assign nband = -band;

   always_comb begin
      case (cfg.shape)
         sdfv_pkg::SHAPE_SPHERE: begin
            d_in = $signed({4'b0000, in_root1}) - rad;
         end
         sdfv_pkg::SHAPE_BOX: begin
            d_in = $signed({4'b0000, in_root1}) + 36'(in_aux);
         end
         sdfv_pkg::SHAPE_TORUS: begin
            d_in = $signed({4'b0000, in_root2}) - rad;
         end
         default: begin
            // capsule: undo the halving
            if (in_big) begin
               d_in = $signed({3'b000, in_root1, 1'b0}) - rad;
            end else begin
               d_in = $signed({4'b0000, in_root1}) - rad;
            end
         end
      endcase
   end

   always_comb begin
      if (d_ff > band) begin
         dist_in = band[31:0];
      end else if (d_ff < nband) begin
         dist_in = nband[31:0];
      end else begin
         dist_in = d_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      dist_ff <= dist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v_ff      <= in_valid;
         strobe_ff <= v_ff;
      end
   end

   assign out_strobe   = strobe_ff;
   assign out_distance = dist_ff;

`ifndef SYNTHESIS
   a_dist_in_band: assert property (@(posedge clock) disable iff (reset)
      out_strobe |-> (out_distance <= $signed({1'b0, $past(cfg.band_limit)}))
                     && (out_distance >= -$signed({1'b0, $past(cfg.band_limit)})))
      else $error("distance outside band");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !out_strobe)
      else $error("result strobe right after reset");
`endif

endmodule

[src/primitive_sdf_voxel_eval.sv]
// Top level of the voxel signed distance evaluator.
// One voxel offset is taken per clock cycle; rsp_strobe rises with the clamped
// distance on rsp_distance (Q16.16 at the default FRAC_BITS). busy is always
// low and the pipeline never stalls; results come out in order and must be
// taken in the cycle they are shown. The pipeline is made of two 34-stage
// square-root pipelines (one root bit per stage), the capsule projection
// divider of FRAC_BITS stages, and setup and clamp stages. Write the registers
// only while no transaction is in flight.
module primitive_sdf_voxel_eval #(
   parameter int FRAC_BITS = sdfv_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [31:0]                req_offset_x,
   input  logic signed [31:0]                req_offset_y,
   input  logic signed [31:0]                req_offset_z,
   output logic                              rsp_strobe,
   output logic signed [31:0]                rsp_distance,
   input  logic                              csr_we,
   input  logic [sdfv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sdfv_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int Side1W = 34;
   localparam int Side2W = Side1W + 32;

   // configuration registers
   sdfv_pkg::cfg_type cfg_in, cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (sdfv_pkg::csr_index_type'(csr_index))
            sdfv_pkg::CSR_SHAPE_KIND:  cfg_in.shape = sdfv_pkg::shape_type'(csr_wdata[1:0]);
            sdfv_pkg::CSR_AXIS_X:      cfg_in.axis_x = $signed(csr_wdata);
            sdfv_pkg::CSR_AXIS_Y:      cfg_in.axis_y = $signed(csr_wdata);
            sdfv_pkg::CSR_AXIS_Z:      cfg_in.axis_z = $signed(csr_wdata);
            sdfv_pkg::CSR_RADIUS:      cfg_in.radius = csr_wdata[30:0];
            sdfv_pkg::CSR_RING_RADIUS: cfg_in.ring_radius = csr_wdata[30:0];
            sdfv_pkg::CSR_BAND_LIMIT:  cfg_in.band_limit = csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{shape: sdfv_pkg::SHAPE_SPHERE, axis_x: '0, axis_y: '0, axis_z: '0,
                     radius: sdfv_pkg::RADIUS_RST, ring_radius: sdfv_pkg::RING_RST,
                     band_limit: sdfv_pkg::BAND_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy = 1'b0;

   // front end
   logic               accept;
   sdfv_pkg::vec3_type in_p, fr_comp;
   logic               fr_valid, fr_big;
   logic signed [32:0] fr_aux;

   assign accept = start && !busy;
   assign in_p   = {req_offset_z, req_offset_y, req_offset_x};

   sdfv_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (accept),
      .in_p     (in_p),
      .out_valid(fr_valid),
      .out_comp (fr_comp),
      .out_aux  (fr_aux),
      .out_big  (fr_big)
   );

   // first root
   logic              s1_valid;
   logic [31:0]       s1_root;
   logic [Side1W-1:0] s1_side;

   sdfv_isqrt #(
      .SIDE_W(Side1W)
   ) u_root1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fr_valid),
      .in_a     (fr_comp),
      .in_side  ({fr_big, fr_aux}),
      .out_valid(s1_valid),
      .out_root (s1_root),
      .out_side (s1_side)
   );

   // torus: distance from the ring in the XZ plane
   logic signed [33:0] ring_diff;
   logic [31:0]        qm_in, qm_ff, mid_root_ff;
   logic [Side1W-1:0]  mid_side_ff;
   logic               mid_v_ff;
   sdfv_pkg::vec3_type s2_a;

   assign ring_diff = $signed({2'b00, s1_root}) - $signed({3'b000, cfg_ff.ring_radius});
   assign qm_in     = ring_diff[33] ? 32'(-ring_diff) : ring_diff[31:0];

   always_ff @(posedge clock) begin
      qm_ff       <= qm_in;
      mid_root_ff <= s1_root;
      mid_side_ff <= s1_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_v_ff <= 1'b0;
      end else begin
         mid_v_ff <= s1_valid;
      end
   end

   always_comb begin
      s2_a = '0;
      if (cfg_ff.shape == sdfv_pkg::SHAPE_TORUS) begin
         s2_a[0] = qm_ff;
         s2_a[1] = mid_side_ff[31:0];
      end
   end

   // second root
   logic              s2_valid;
   logic [31:0]       s2_root;
   logic [Side2W-1:0] s2_side;

   sdfv_isqrt #(
      .SIDE_W(Side2W)
   ) u_root2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mid_v_ff),
      .in_a     (s2_a),
      .in_side  ({mid_side_ff, mid_root_ff}),
      .out_valid(s2_valid),
      .out_root (s2_root),
      .out_side (s2_side)
   );

   sdfv_final u_final (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (s2_valid),
      .in_root1    (s2_side[31:0]),
      .in_root2    (s2_root),
      .in_aux      ($signed(s2_side[64:32])),
      .in_big      (s2_side[65]),
      .out_strobe  (rsp_strobe),
      .out_distance(rsp_distance)
   );

endmodule
